[rtl/core/fih_pkg.sv]
// Shared constants, item kind codes and stack interface structs for the
// FNV-1a identifier stack hasher. No dependencies.
package fih_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Field widths
  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int ID_W    = 32;
  localparam int DEPTH_W = 6;
  localparam int RUN_W   = 2;

  // FNV-1a 32-bit constants and the restart mark character
  localparam logic [ID_W-1:0]   FNV_BASIS = 32'd2166136261;
  localparam logic [ID_W-1:0]   FNV_PRIME = 32'd16777619;
  localparam logic [BYTE_W-1:0] MARK_BYTE = 8'h23;
  localparam logic [RUN_W-1:0]  RUN_FULL  = 2'd3;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_BYTE      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_END_PUSH  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END_QUERY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PUSH_NUM  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PUSH_RAW  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP       = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd6;

  // Stack operation request from the item decoder
  typedef struct packed {
    logic            push;
    logic            pop;
    logic            clear;
    logic [ID_W-1:0] value;
  } stk_ctrl_t;

  // Stack status, now and after the operation in hand
  typedef struct packed {
    logic [SP_W-1:0] sp;
    logic            full;
    logic [ID_W-1:0] seed;
    logic [SP_W-1:0] sp_nxt;
    logic [ID_W-1:0] seed_nxt;
  } stk_stat_t;

endpackage

[rtl/core/fih_fnv_step.sv]
// One FNV-1a round: XOR the data into the hash, multiply by the prime.
// Depends on fih_pkg.
module fih_fnv_step (
  input  logic [fih_pkg::ID_W-1:0] hash_i,
  input  logic [fih_pkg::ID_W-1:0] data_i,
  output logic [fih_pkg::ID_W-1:0] hash_o
);
  import fih_pkg::*;

  logic [ID_W-1:0] mix;

  // Constant multiply, low 32 bits kept (shift-and-add in synthesis)
  assign mix    = hash_i ^ data_i;
  assign hash_o = ID_W'(mix * FNV_PRIME);

endmodule

[rtl/core/fih_id_stack.sv]
// Identifier stack: top held in a register, the rest in a memory with a
// registered read that always fetches the entry under the top.
// Depends on fih_pkg.
module fih_id_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  fih_pkg::stk_ctrl_t ctrl,
  output fih_pkg::stk_stat_t stat
);
  import fih_pkg::*;

  logic [ID_W-1:0]   mem [STACK_DEPTH];
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [ID_W-1:0]   top_r, top_nxt;
  logic [ID_W-1:0]   below_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic              full;

  assign full = (sp_r == SP_W'(STACK_DEPTH));

  // Work out the next pointer and top for the operation in hand
  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    wr_en   = 1'b0;
    if (en) begin
      priority if (ctrl.clear) begin
        sp_nxt = '0;
      end else if (ctrl.push && !full) begin
        sp_nxt  = sp_r + SP_W'(1);
        top_nxt = ctrl.value;
        wr_en   = 1'b1;
      end else if (ctrl.pop && (sp_r != '0)) begin
        sp_nxt  = sp_r - SP_W'(1);
        top_nxt = below_r;
      end
    end
  end

  // Entry under the new top; never the slot being written this cycle
  assign rd_addr = ADDR_W'(sp_nxt - SP_W'(2));

  // Pointer register, cleared on reset; the top is not reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  // Stack memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sp_r[ADDR_W-1:0]] <= ctrl.value;
    end
    below_r <= mem[rd_addr];
  end

  assign stat.sp       = sp_r;
  assign stat.full     = full;
  assign stat.seed     = (sp_r != '0) ? top_r : FNV_BASIS;
  assign stat.sp_nxt   = sp_nxt;
  assign stat.seed_nxt = (sp_nxt != '0) ? top_nxt : FNV_BASIS;

endmodule

[rtl/core/fnv1a_id_stack_hasher.sv]
// Top level of the FNV-1a identifier stack hasher: input register, item
// decoder, running hash state and result register.
// Depends on fih_pkg, fih_fnv_step and fih_id_stack.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready with the item kind on
//   in_tuser and the name byte and value on in_tdata. Each input word
//   gives exactly one result word on out_tvalid/out_tready carrying the
//   identifier, the stack depth after the item and the overflow flag.
//   A word accepted passes through the input register and then the
//   result register, which presents it on out_tvalid/out_tready.
//   Throughput: one word per cycle while the receiver takes every
//   result; the hash round (XOR and constant multiply) and the stack
//   update are combinational between the input and result registers.
//   When the receiver stalls, the result register holds its word and the
//   input register takes one more word, after which in_tready drops
//   until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers and the stack
//   and reloads the running hash with the offset basis. Stack memory is
//   not cleared; only entries below the stack pointer are ever used.
module fnv1a_id_stack_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // name_byte[7:0], value[39:8]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // identifier[31:0], stack_depth[37:32],
                                  // overflow[38], zero pad[39]
);
  import fih_pkg::*;

  // Input register
  logic              in_valid_r, in_valid_nxt;
  logic [KIND_W-1:0] in_kind_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic [ID_W-1:0]   in_value_r;

  // Running name state
  logic [ID_W-1:0]   hash_r, hash_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [RUN_W-1:0]  run_inc;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    ident_r, ident_nxt;
  logic [DEPTH_W-1:0] depth_r;
  logic               ovf_r, ovf_nxt;

  logic              advance;
  logic              in_accept;
  logic [ID_W-1:0]   step_hash_in, step_data_in, step_hash;
  stk_ctrl_t         ctrl;
  stk_stat_t         stat;

  // Handshake: move a word on when the result register is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_kind_r  <= in_tuser;
      in_byte_r  <= in_tdata[7:0];
      in_value_r <= in_tdata[39:8];
    end
  end

  // Shared hash round: running hash with a byte, or seed with a number
  assign step_hash_in = (in_kind_r == KIND_PUSH_NUM) ? stat.seed : hash_r;
  assign step_data_in = (in_kind_r == KIND_PUSH_NUM) ? in_value_r
                                                     : ID_W'(in_byte_r);

  fih_fnv_step u_step (
    .hash_i (step_hash_in),
    .data_i (step_data_in),
    .hash_o (step_hash)
  );

  // Decode the stack operation
  always_comb begin
    ctrl = '0;
    unique case (in_kind_r)
      KIND_END_PUSH: begin
        ctrl.push  = 1'b1;
        ctrl.value = hash_r;
      end
      KIND_PUSH_NUM: begin
        ctrl.push  = 1'b1;
        ctrl.value = step_hash;
      end
      KIND_PUSH_RAW: begin
        ctrl.push  = 1'b1;
        ctrl.value = in_value_r;
      end
      KIND_POP:   ctrl.pop   = 1'b1;
      KIND_CLEAR: ctrl.clear = 1'b1;
      default:    ctrl       = '0;
    endcase
  end

  fih_id_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // Saturating count of consecutive marks
  assign run_inc = (run_r == RUN_FULL) ? RUN_FULL : run_r + RUN_W'(1);

  // Result and next name state; stack operations and queries restart the name
  always_comb begin
    hash_nxt  = hash_r;
    run_nxt   = run_r;
    ident_nxt = hash_r;
    ovf_nxt   = 1'b0;
    unique case (in_kind_r)
      KIND_BYTE: begin
        if (in_byte_r == MARK_BYTE) begin
          run_nxt  = run_inc;
          hash_nxt = (run_inc == RUN_FULL) ? stat.seed : step_hash;
        end else begin
          run_nxt  = '0;
          hash_nxt = step_hash;
        end
        ident_nxt = hash_nxt;
      end
      KIND_END_PUSH, KIND_PUSH_NUM, KIND_PUSH_RAW: begin
        ident_nxt = ctrl.value;
        ovf_nxt   = stat.full;
        hash_nxt  = stat.seed_nxt;
        run_nxt   = '0;
      end
      KIND_END_QUERY: begin
        ident_nxt = hash_r;
        hash_nxt  = stat.seed_nxt;
        run_nxt   = '0;
      end
      KIND_POP: begin
        ident_nxt = (stat.sp_nxt != '0) ? stat.seed_nxt : '0;
        hash_nxt  = stat.seed_nxt;
        run_nxt   = '0;
      end
      KIND_CLEAR: begin
        ident_nxt = '0;
        hash_nxt  = stat.seed_nxt;
        run_nxt   = '0;
      end
      default: begin
        ident_nxt = hash_r;
      end
    endcase
  end

  // Advance name state with each processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      run_r  <= '0;
    end else if (advance) begin
      hash_r <= hash_nxt;
      run_r  <= run_nxt;
    end
  end

  // Result register: load on advance, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ident_r <= ident_nxt;
      depth_r <= DEPTH_W'(stat.sp_nxt);
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, ovf_r, depth_r, ident_r};

  // Overflow is only reported with a full stack
  a_ovf_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> (depth_r == DEPTH_W'(STACK_DEPTH)))
    else $error("overflow flagged below full depth");

  // A processed clear leaves the stack empty
  a_clear_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (in_kind_r == KIND_CLEAR)) |=> (stat.sp == '0))
    else $error("stack not empty after clear");

  // Every processed word lands in the result register
  a_adv_result : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed word produced no result");

  // The stack pointer moves only with a processed word
  a_sp_bound : assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) || $stable(stat.sp) || (stat.sp == '0))
    else $error("stack pointer moved without a processed word");

endmodule

[dv/tb.sv]
// Self-checking bench for fnv1a_id_stack_hasher: directed table then random name,
// push, pop and clear traffic, scored against an in-bench stack and FNV-1a hash.
// Depends on fih_pkg and the RTL top level only.
module tb;
  import fih_pkg::*;

  // Kind code the block leaves unused: no change of state
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 80;

  typedef struct packed {
    logic [ID_W-1:0]    identifier;
    logic [DEPTH_W-1:0] depth;
    logic               overflow;
  } stack_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] name_byte;
    logic [ID_W-1:0]   value;
    logic              typed;
    stack_result_t     want;
  } dir_row_t;

  localparam stack_result_t NO_WANT = '0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // name_byte[7:0], value[39:8]
  logic [2:0]  in_tuser;   // kind[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // identifier[31:0], stack_depth[37:32], overflow[38], pad[39]

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req = 1'b0;
  int items_sent = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  stack_result_t results_owed[$];

  // Predicted block state
  logic [ID_W-1:0]  id_mem [STACK_DEPTH];
  int               stack_ptr = 0;
  logic [ID_W-1:0]  name_hash = FNV_BASIS;
  logic [RUN_W-1:0] mark_run = '0;

  fnv1a_id_stack_hasher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed words: typed results only where they are obvious
  dir_row_t dir_rows [24] = '{
    '{KIND_POP,       8'h00,     32'h0,        1'b1, '{32'h0,        6'd0, 1'b0}},
    '{KIND_CLEAR,     8'h00,     32'h0,        1'b1, '{32'h0,        6'd0, 1'b0}},
    '{KIND_PUSH_RAW,  8'h00,     32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 6'd1, 1'b0}},
    '{KIND_PUSH_RAW,  8'hFF,     32'h0,        1'b1, '{32'h0,        6'd2, 1'b0}},
    '{KIND_BYTE,      8'h00,     32'h0,        1'b1, '{32'h0,        6'd2, 1'b0}},
    '{KIND_BYTE,      8'hFF,     32'h0,        1'b0, NO_WANT},
    '{KIND_BYTE,      MARK_BYTE, 32'h0,        1'b0, NO_WANT},
    '{KIND_BYTE,      MARK_BYTE, 32'h0,        1'b0, NO_WANT},
    '{KIND_BYTE,      MARK_BYTE, 32'h0,        1'b1, '{32'h0,        6'd2, 1'b0}},
    '{KIND_BYTE,      MARK_BYTE, 32'h0,        1'b1, '{32'h0,        6'd2, 1'b0}},
    '{KIND_BYTE,      8'h61,     32'h0,        1'b0, NO_WANT},
    '{KIND_END_QUERY, 8'h00,     32'h0,        1'b0, NO_WANT},
    '{KIND_BYTE,      MARK_BYTE, 32'h0,        1'b0, NO_WANT},
    '{KIND_BYTE,      MARK_BYTE, 32'h0,        1'b0, NO_WANT},
    '{KIND_BYTE,      8'h00,     32'h0,        1'b0, NO_WANT},
    '{KIND_BYTE,      MARK_BYTE, 32'h0,        1'b0, NO_WANT},
    '{KIND_END_PUSH,  8'h00,     32'h0,        1'b0, NO_WANT},
    '{KIND_PUSH_NUM,  8'h00,     32'h0,        1'b0, NO_WANT},
    '{KIND_PUSH_NUM,  8'h00,     32'hFFFFFFFF, 1'b0, NO_WANT},
    '{KIND_UNUSED,    8'h5A,     32'hA5A5A5A5, 1'b0, NO_WANT},
    '{KIND_BYTE,      8'h71,     32'h0,        1'b0, NO_WANT},
    '{KIND_PUSH_RAW,  8'h00,     32'h12345678, 1'b0, NO_WANT},
    '{KIND_POP,       8'h00,     32'h0,        1'b0, NO_WANT},
    '{KIND_CLEAR,     8'h00,     32'h0,        1'b1, '{32'h0,        6'd0, 1'b0}}
  };

  // One FNV-1a round, truncated to 32 bits
  function automatic logic [ID_W-1:0] fnv_round(input logic [ID_W-1:0] h,
                                                input logic [ID_W-1:0] b);
    logic [ID_W-1:0] p;
    p = (h ^ b) * FNV_PRIME;
    return p;
  endfunction

  // Seed for a new name: top of stack, or the offset basis when empty
  function logic [ID_W-1:0] stack_seed();
    return (stack_ptr == 0) ? FNV_BASIS : id_mem[stack_ptr-1];
  endfunction

  function bit push_id(input logic [ID_W-1:0] v);
    if (stack_ptr >= STACK_DEPTH) return 1'b0;
    id_mem[stack_ptr] = v;
    stack_ptr++;
    return 1'b1;
  endfunction

  task restart_name();
    name_hash = stack_seed();
    mark_run = '0;
  endtask

  // Advance the predicted state by one word and work out its result
  task apply_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] nb,
                  input logic [ID_W-1:0] val, output stack_result_t res);
    logic [ID_W-1:0] ident;
    logic            ovf;
    ident = name_hash;
    ovf = 1'b0;
    case (kind)
      KIND_BYTE: begin
        name_hash = fnv_round(name_hash, {24'd0, nb});
        if (nb == MARK_BYTE) begin
          if (mark_run != RUN_FULL) mark_run++;
          if (mark_run == RUN_FULL) name_hash = stack_seed();
        end else begin
          mark_run = '0;
        end
        ident = name_hash;
      end
      KIND_END_PUSH: begin
        ovf = !push_id(ident);
        restart_name();
      end
      KIND_END_QUERY: restart_name();
      KIND_PUSH_NUM: begin
        ident = fnv_round(stack_seed(), val);
        ovf = !push_id(ident);
        restart_name();
      end
      KIND_PUSH_RAW: begin
        ident = val;
        ovf = !push_id(ident);
        restart_name();
      end
      KIND_POP: begin
        if (stack_ptr > 0) stack_ptr--;
        ident = (stack_ptr > 0) ? stack_seed() : '0;
        restart_name();
      end
      KIND_CLEAR: begin
        stack_ptr = 0;
        ident = '0;
        restart_name();
      end
      default: ident = name_hash;
    endcase
    res.identifier = ident;
    res.depth = DEPTH_W'(stack_ptr);
    res.overflow = ovf;
  endtask

  // Offer one word, wait for the handshake, then log what it owes
  task automatic offer_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] nb,
                            input logic [ID_W-1:0] val, input logic typed,
                            input stack_result_t want);
    stack_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {val, nb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_word(kind, nb, val, predicted);
    results_owed.insert(results_owed.size(), typed ? want : predicted);
    if (kind != KIND_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] nb,
                         input logic [ID_W-1:0] val);
    offer_word(kind, nb, val, 1'b0, NO_WANT);
  endtask

  // Name characters lean heavily on the restart mark
  function automatic logic [BYTE_W-1:0] pick_name_byte();
    return ($urandom_range(99) < 35) ? MARK_BYTE : BYTE_W'($urandom_range(255));
  endfunction

  // Push until full, then push a few more so they are dropped
  task automatic fill_stack();
    while (stack_ptr < STACK_DEPTH)
      send_op($urandom_range(1) ? KIND_PUSH_NUM : KIND_PUSH_RAW, pick_name_byte(), $urandom);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(2))
        0:       send_op(KIND_END_PUSH, pick_name_byte(), $urandom);
        1:       send_op(KIND_PUSH_NUM, pick_name_byte(), $urandom);
        default: send_op(KIND_PUSH_RAW, pick_name_byte(), $urandom);
      endcase
    end
  endtask

  // Complete names most often, plus stack traffic, broken names and noise
  task automatic run_random(input int target);
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 10)) send_op(KIND_BYTE, pick_name_byte(), $urandom);
        send_op(($urandom_range(99) < 55) ? KIND_END_PUSH : KIND_END_QUERY,
                pick_name_byte(), $urandom);
      end else if (pick < 60) begin
        send_op($urandom_range(1) ? KIND_PUSH_NUM : KIND_PUSH_RAW, pick_name_byte(), $urandom);
      end else if (pick < 70) begin
        send_op(KIND_POP, pick_name_byte(), $urandom);
      end else if (pick < 73) begin
        send_op(KIND_CLEAR, pick_name_byte(), $urandom);
      end else if (pick < 77) begin
        fill_stack();
      end else if (pick < 80) begin
        // pop down to empty and once more
        while (stack_ptr > 0) send_op(KIND_POP, pick_name_byte(), $urandom);
        send_op(KIND_POP, pick_name_byte(), $urandom);
      end else if (pick < 92) begin
        // abandon a name part way through
        repeat ($urandom_range(1, 4)) send_op(KIND_BYTE, pick_name_byte(), $urandom);
        case ($urandom_range(3))
          0:       send_op(KIND_PUSH_NUM, pick_name_byte(), $urandom);
          1:       send_op(KIND_PUSH_RAW, pick_name_byte(), $urandom);
          2:       send_op(KIND_POP, pick_name_byte(), $urandom);
          default: send_op(KIND_CLEAR, pick_name_byte(), $urandom);
        endcase
      end else begin
        send_op(KIND_W'($urandom_range(7)), BYTE_W'($urandom_range(255)), $urandom);
      end
    end
  endtask

  // Receiver: random back-pressure, or a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Score each result word against the oldest one owed
  always @(posedge clk) begin
    stack_result_t owed;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_owed.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        mismatch_count++;
      end else begin
        owed = results_owed.pop_front();
        if (out_tdata[31:0] !== owed.identifier) begin
          $error("identifier: expected %h, actual %h", owed.identifier, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[37:32] !== owed.depth) begin
          $error("stack_depth: expected %0d, actual %0d", owed.depth, out_tdata[37:32]);
          mismatch_count++;
        end
        if (out_tdata[38] !== owed.overflow) begin
          $error("overflow: expected %b, actual %b", owed.overflow, out_tdata[38]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = KIND_BYTE;
    in_tdata = '0;
    send_idle_pct = 32;
    recv_idle_pct = 45;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      offer_word(dir_rows[i].kind, dir_rows[i].name_byte, dir_rows[i].value,
                 dir_rows[i].typed, dir_rows[i].want);

    // Hold the receiver off while words keep coming, so the input stalls
    hold_off_req = 1'b1;
    run_random(items_sent + 12);
    in_tvalid = 1'b0;
    // Pause until every result has been taken
    while (results_owed.size() != 0) @(negedge clk);

    fill_stack();
    run_random(500);

    send_idle_pct = 45;
    recv_idle_pct = 32;
    run_random(980);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(1460);
    in_tvalid = 1'b0;

    while (results_owed.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_owed.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

[sim.f]
rtl/core/fih_pkg.sv
rtl/core/fih_fnv_step.sv
rtl/core/fih_id_stack.sv
rtl/core/fnv1a_id_stack_hasher.sv
dv/tb.sv
